// ===== sv/ksort_pkg.sv =====
// Shared types and constants for the k-sorted stream sorter.
// No dependencies; used by the interfaces, the cell and the top level.
`default_nettype none

package ksort_pkg;

  localparam int VALUE_W        = 32;
  localparam int K_W            = 5;
  localparam int HEAP_DEPTH_DEF = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // one slot of the sorted chain
  typedef struct packed {
    logic   vld;
    value_t val;
  } cell_t;

  // operation broadcast to every cell in a cycle
  typedef struct packed {
    logic   pop;
    logic   ins;
    value_t v;
  } cell_op_t;

endpackage

`default_nettype wire

// ===== sv/ksort_if.sv =====
// Valid/ready channel interfaces for input words, result words and config writes.
// Depends on ksort_pkg.
`default_nettype none

interface ksort_in_if import ksort_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;
  logic   is_last;
  modport source(output valid, value, is_last, input ready);
  modport sink(input valid, value, is_last, output ready);
endinterface

interface ksort_out_if import ksort_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   end_of_array;
  modport source(output valid, sorted_value, end_of_array, input ready);
  modport sink(input valid, sorted_value, end_of_array, output ready);
endinterface

interface ksort_cfg_if import ksort_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [K_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

`default_nettype wire

// ===== sv/ksort_cell.sv =====
// One slot of the sorted chain: pops shift left, inserts shift right past the slot.
// Depends on ksort_pkg.
`default_nettype none

module ksort_cell import ksort_pkg::*; #(
  parameter bit HEAD = 1'b0
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cell_op_t op,
  input  wire cell_t    left_i,
  input  wire cell_t    right_i,
  output cell_t         q_o
);

  cell_t slot_r;
  cell_t slot_nxt;
  cell_t a;
  cell_t b;
  logic  a_vld;
  logic  shift_r;
  logic  take_v;

  // a: predecessor after the pop, b: this slot after the pop
  always_comb begin
    a        = op.pop ? slot_r : left_i;
    b        = op.pop ? right_i : slot_r;
    a_vld    = HEAD ? 1'b0 : a.vld;
    shift_r  = op.ins && a_vld && (op.v < a.val);
    take_v   = op.ins && !shift_r && (HEAD || a_vld) && (!b.vld || (op.v < b.val));
    slot_nxt = b;
    if (shift_r) begin
      slot_nxt = a;
    end else if (take_v) begin
      slot_nxt.vld = 1'b1;
      slot_nxt.val = op.v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.vld <= 1'b0;
    end else begin
      slot_r.vld <= slot_nxt.vld;
    end
    slot_r.val <= slot_nxt.val;
  end

  assign q_o = slot_r;

endmodule

`default_nettype wire

// ===== sv/k_sorted_stream_sorter.sv =====
// An input word is taken in S_IDLE, then processed in S_PROC, which waits while a pop is
// due and out_ch cannot accept; a popped minimum is registered in out_val_r for out_ch. A new
// word is taken only after the last is processed; pop and insert happen in the same cycle.
// A last word then drains the chain at one result per cycle while out_ch is ready.
// Reset clears the window, the fill count and every cell valid bit; no clearing pass.
`default_nettype none

module k_sorted_stream_sorter import ksort_pkg::*; #(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ksort_in_if.sink    in_ch,
  ksort_out_if.source out_ch,
  ksort_cfg_if.sink   cfg_ch
);

  localparam int CW   = $clog2(HEAP_DEPTH + 1);
  localparam int CMPW = (CW > K_W + 1) ? CW : K_W + 1;

  typedef enum logic [1:0] {S_IDLE, S_PROC, S_DRAIN} state_t;

  state_t         state_r, state_nxt;
  logic [K_W-1:0] window_k_r;
  logic [CW-1:0]  count_r, count_nxt;
  value_t         item_val_r;
  logic           item_last_r;
  value_t         out_val_r;
  logic           out_last_r;
  logic           out_valid_r;

  cell_op_t       op;
  cell_t          chain_q [HEAP_DEPTH];
  logic [HEAP_DEPTH-1:0] vld_vec;
  logic [CMPW-1:0] kp1, cap;
  logic           need_pop, out_free, do_emit, emit_last;

  genvar gi;
  generate
    for (gi = 0; gi < HEAP_DEPTH; gi++) begin : g_cell
      cell_t left_w, right_w;
      if (gi == 0) begin : g_l0
        assign left_w = '0;
      end else begin : g_ln
        assign left_w = chain_q[gi-1];
      end
      if (gi == HEAP_DEPTH - 1) begin : g_r0
        assign right_w = '0;
      end else begin : g_rn
        assign right_w = chain_q[gi+1];
      end
      ksort_cell #(.HEAD(gi == 0)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .left_i (left_w),
        .right_i(right_w),
        .q_o    (chain_q[gi])
      );
      assign vld_vec[gi] = chain_q[gi].vld;
    end
  endgenerate

  always_comb begin
    kp1      = CMPW'(window_k_r) + CMPW'(1);
    cap      = (kp1 > CMPW'(HEAP_DEPTH)) ? CMPW'(HEAP_DEPTH) : kp1;
    need_pop = CMPW'(count_r) >= cap;
    out_free = !out_valid_r || out_ch.ready;

    op        = '0;
    op.v      = item_val_r;
    do_emit   = 1'b0;
    emit_last = 1'b0;
    count_nxt = count_r;
    state_nxt = state_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_PROC;
        end
      end
      S_PROC: begin
        if (!need_pop || out_free) begin
          op.pop    = need_pop;
          op.ins    = 1'b1;
          do_emit   = need_pop;
          count_nxt = need_pop ? count_r : count_r + CW'(1);
          state_nxt = item_last_r ? S_DRAIN : S_IDLE;
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          op.pop    = 1'b1;
          do_emit   = 1'b1;
          emit_last = (count_r == CW'(1));
          count_nxt = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      window_k_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_ch.valid) begin
        window_k_r <= cfg_ch.data;
      end
      if (do_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (state_r == S_IDLE && in_ch.valid) begin
      item_val_r  <= in_ch.value;
      item_last_r <= in_ch.is_last;
    end
    if (do_emit) begin
      out_val_r  <= chain_q[0].val;
      out_last_r <= emit_last;
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_val_r;
  assign out_ch.end_of_array = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(count_r) <= CMPW'(HEAP_DEPTH))
    else $error("fill count beyond depth");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) == int'(count_r))
    else $error("cell valid bits disagree with fill count");

  a_head_min: assert property (@(posedge clk) disable iff (!rst_n)
    vld_vec[1] |-> !(chain_q[1].val < chain_q[0].val))
    else $error("head cell does not hold the minimum");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> (count_r != '0))
    else $error("drain with empty chain");

endmodule

`default_nettype wire

// ===== tb/k_sorted_stream_sorter_test.sv =====
// Self-checking test of k_sorted_stream_sorter: directed and random arrays, most of them
// k-sorted, with window changes, bursty input and stalling output, checked against a
// sorted-window model. Depends on ksort_pkg, ksort_if and the k_sorted_stream_sorter RTL.
`default_nettype none

module k_sorted_stream_sorter_test;
  import ksort_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RST_CYCLES    = 9;
  localparam int SETTLE_CYCLES = 12;
  localparam int IDLE_LIMIT    = 5000;
  localparam int RAND_WORDS    = 125;
  localparam int TAIL_CYCLES   = 20;

  typedef enum logic [1:0] {ENT_WORD, ENT_CFG, ENT_SETTLE} ent_kind_t;

  typedef struct {
    ent_kind_t      kind;
    value_t         val;
    logic           last;
    logic [K_W-1:0] k;
  } stim_ent_t;

  typedef struct {
    value_t val;
    logic   eoa;
  } sorted_word_t;

  logic clk = 1'b0;
  logic rst_n;

  ksort_in_if  in_ch();
  ksort_out_if out_ch();
  ksort_cfg_if cfg_ch();

  k_sorted_stream_sorter i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stim_ent_t      stim_q[$];
  sorted_word_t   sorted_due_q[$];
  value_t         held_vals[$];
  logic [K_W-1:0] cur_window;
  int             mismatches;
  int             burst_left;
  int             gap_left;
  int             settle_cnt;
  int             stall_mode;
  int             rx_cyc;
  int             idle_cyc;
  logic           rdy;
  sorted_word_t   want;

  // window model: held values kept in ascending order, front is the minimum
  task automatic predict_sorted(input value_t v, input logic last);
    int           cap;
    int           pos;
    sorted_word_t w;
    cap = int'(cur_window) + 1;
    if (cap > HEAP_DEPTH_DEF) cap = HEAP_DEPTH_DEF;
    if (held_vals.size() >= cap) begin
      w.val = held_vals.pop_front();
      w.eoa = 1'b0;
      sorted_due_q.insert(sorted_due_q.size(), w);
    end
    pos = 0;
    while (pos < held_vals.size() && held_vals[pos] <= v) pos++;
    held_vals.insert(pos, v);
    if (last) begin
      while (held_vals.size() != 0) begin
        w.val = held_vals.pop_front();
        w.eoa = (held_vals.size() == 0);
        sorted_due_q.insert(sorted_due_q.size(), w);
      end
    end
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic push_word(input value_t v, input logic last);
    stim_ent_t e;
    e.kind = ENT_WORD;
    e.val  = v;
    e.last = last;
    e.k    = '0;
    stim_q.insert(stim_q.size(), e);
  endtask

  // drain outstanding results before touching the window
  task automatic push_window(input int k);
    stim_ent_t e;
    e.kind = ENT_SETTLE;
    e.val  = '0;
    e.last = 1'b0;
    e.k    = '0;
    stim_q.insert(stim_q.size(), e);
    e.kind = ENT_CFG;
    e.k    = k[K_W-1:0];
    stim_q.insert(stim_q.size(), e);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      cfg_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
      settle_cnt = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_sorted(stim_q[0].val, stim_q[0].last);
        void'(stim_q.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          burst_left = $urandom_range(1, 24);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        cur_window = stim_q[0].k;
        void'(stim_q.pop_front());
      end
      if (stim_q.size() != 0 && stim_q[0].kind == ENT_SETTLE) begin
        if (sorted_due_q.size() == 0) settle_cnt++;
        else settle_cnt = 0;
        if (settle_cnt > SETTLE_CYCLES) begin
          void'(stim_q.pop_front());
          settle_cnt = 0;
        end
      end
      if (stim_q.size() != 0 && stim_q[0].kind == ENT_WORD && gap_left == 0) begin
        in_ch.valid   <= 1'b1;
        in_ch.value   <= stim_q[0].val;
        in_ch.is_last <= stim_q[0].last;
      end else begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0 && stim_q.size() != 0 && stim_q[0].kind == ENT_WORD) gap_left--;
      end
      if (stim_q.size() != 0 && stim_q[0].kind == ENT_CFG) begin
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= stim_q[0].k;
      end else begin
        cfg_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_mode = 0;
      rx_cyc     = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (sorted_due_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected word: sorted_value %0d end_of_array %0b",
                                  out_ch.sorted_value, out_ch.end_of_array));
        end else begin
          want = sorted_due_q.pop_front();
          if (out_ch.sorted_value !== want.val)
            flag_mismatch($sformatf("sorted_value exp %0d got %0d",
                                    want.val, out_ch.sorted_value));
          if (out_ch.end_of_array !== want.eoa)
            flag_mismatch($sformatf("end_of_array exp %0b got %0b (value %0d)",
                                    want.eoa, out_ch.end_of_array, want.val));
        end
      end
      rx_cyc++;
      if (rx_cyc % 50 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 3) != 0);
        2:       rdy = ((rx_cyc % 5) < 2);
        default: rdy = ($urandom_range(0, 7) == 0);
      endcase
      out_ch.ready <= rdy;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cyc = 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cyc = 0;
      else
        idle_cyc++;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int   words;
    int   k;
    int   n;
    int   split;
    int   r;
    int   i;
    int   j;
    int   t;
    int   base;
    int   arr[$];
    logic wellformed;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    in_ch.is_last = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    out_ch.ready  = 1'b0;
    cur_window    = '0;
    mismatches    = 0;

    // window 0: every word pushes out the previous one; field extremes
    push_window(0);
    push_word(32'sh8000_0000, 1'b0);
    push_word(32'sh7FFF_FFFF, 1'b0);
    push_word(-32'sd1, 1'b0);
    push_word(32'sd0, 1'b1);
    // single-word array
    push_word(32'sd7, 1'b1);
    // equal values
    push_window(3);
    push_word(32'sd5, 1'b0);
    push_word(32'sd5, 1'b0);
    push_word(-32'sd3, 1'b0);
    push_word(32'sd5, 1'b0);
    push_word(32'sh7FFF_FFFF, 1'b0);
    push_word(32'sd5, 1'b1);
    // widest window, array shorter than the heap
    push_window(31);
    push_word(32'sd40, 1'b0);
    push_word(32'sh8000_0000, 1'b0);
    push_word(32'sd12, 1'b0);
    push_word(32'sh7FFF_FFFF, 1'b1);
    // window shrunk mid-stream
    push_window(5);
    for (i = 0; i < 8; i++) push_word(i * 3 - ((i % 2) ? 10 : 0), 1'b0);
    push_window(1);
    push_word(-32'sd100, 1'b0);
    push_word(32'sd100, 1'b1);

    words = 0;
    k     = 1;
    while (words < RAND_WORDS) begin
      r = $urandom_range(0, 9);
      if (r < 2)      k = 0;
      else if (r < 3) k = 31;
      else if (r < 4) k = 1;
      else            k = $urandom_range(2, 8);
      if (k != int'(cur_window) || $urandom_range(0, 3) == 0) push_window(k);
      cur_window = k[K_W-1:0];
      n = (k == 31) ? $urandom_range(1, 45) : $urandom_range(1, 3 * (k + 1) + 2);
      arr.delete();
      base = $urandom;
      for (i = 0; i < n; i++) begin
        r = $urandom_range(0, 9);
        if (r < 4)       arr.insert(arr.size(), $urandom);
        else if (r == 4) arr.insert(arr.size(), ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF
                                                                            : 32'sh8000_0000);
        else begin
          base = base + $urandom_range(0, 50);
          arr.insert(arr.size(), base);
        end
      end
      arr.sort();
      wellformed = ($urandom_range(0, 4) != 0);
      if (wellformed) begin
        for (i = 0; i < n; i += k + 1) begin
          for (j = ((i + k < n) ? i + k : n - 1); j > i; j--) begin
            r = $urandom_range(i, j);
            t = arr[j];
            arr[j] = arr[r];
            arr[r] = t;
          end
        end
      end else begin
        arr.shuffle();
      end
      split = (n > 2 && $urandom_range(0, 5) == 0) ? $urandom_range(1, n - 1) : n;
      for (i = 0; i < n; i++) begin
        if (i == split) begin
          k = $urandom_range(0, k);
          push_window(k);
          cur_window = k[K_W-1:0];
        end
        push_word(arr[i], i == n - 1);
        words++;
      end
    end
    cur_window = '0;

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || sorted_due_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && sorted_due_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
